// ----- hdl/mlt_pkg.sv -----
// Shared constants, codes and control types for the MAC learning table.
package mlt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int PORT_COUNT    = 16;
    localparam int INDEX_W       = $clog2(TABLE_ENTRIES);

    localparam int OP_W      = 2;
    localparam int MAC_W     = 48;
    localparam int PORT_W    = 4;
    localparam int STATUS_W  = 2;
    localparam int AGED_W    = 7;
    localparam int STAMP_W   = 32;
    localparam int TIMEOUT_W = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;
    localparam logic [AGED_W-1:0]    AGED_MAX      = 7'd127;

    // Operation codes; the unused code does nothing and returns an all-zero result.
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_LEARN  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Learn status codes.
    localparam logic [STATUS_W-1:0] ST_NONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFRESHED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 2'd3;

    typedef struct packed {
        logic               load;
        logic               rd_en;
        logic [INDEX_W-1:0] rd_addr;
        logic               commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

// ----- hdl/mlt_in_if.sv -----
// Input channel carrying one table operation per transaction.
interface mlt_in_if;
    import mlt_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [MAC_W-1:0]  mac_address;
    logic [PORT_W-1:0] port_number;

    modport source (output valid, output operation, output mac_address,
                    output port_number, input ready);
    modport sink   (input valid, input operation, input mac_address,
                    input port_number, output ready);
endinterface

// ----- hdl/mlt_out_if.sv -----
// Output channel carrying one operation result per transaction.
interface mlt_out_if;
    import mlt_pkg::*;

    logic                valid;
    logic                ready;
    logic                found;
    logic [PORT_W-1:0]   found_port;
    logic [STATUS_W-1:0] learn_status;
    logic [AGED_W-1:0]   aged_count;

    modport source (output valid, output found, output found_port,
                    output learn_status, output aged_count, input ready);
    modport sink   (input valid, input found, input found_port,
                    input learn_status, input aged_count, output ready);
endinterface

// ----- hdl/mac_learning_table_with_aging.sv -----
// An accepted operation is processed in order: the scan reads one table entry per cycle, a settle
// step evaluates the last entry read, and a commit step writes the table and the result register.
// A new operation is accepted only once the previous one has committed and the block is idle again.
// A result waits in the output register while the next operation is scanned; if it is still
// waiting when the next one is ready, the controller holds in its commit cycle.
// Reset clears all valid bits, the seconds counter and the timeout (to 30) at once.
module mac_learning_table_with_aging (
    input  logic                          clk,
    input  logic                          rst_n,
    mlt_in_if.sink                        item,
    mlt_out_if.source                     result,
    input  logic                          cfg_we,
    input  logic [mlt_pkg::TIMEOUT_W-1:0] cfg_data
);
    import mlt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       ctrl_ready;

    assign item.ready = ctrl_ready;

    mlt_controller u_controller (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (ctrl_ready),
        .cmd        (cmd),
        .status     (status)
    );

    mlt_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .operation   (item.operation),
        .mac_address (item.mac_address),
        .port_number (item.port_number),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .result      (result)
    );

endmodule

// ----- hdl/mlt_datapath.sv -----
// Table storage, entry scan evaluation and result register.
module mlt_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mlt_pkg::ctrl_cmd_t           cmd,
    output mlt_pkg::dp_status_t          status,
    input  logic [mlt_pkg::OP_W-1:0]     operation,
    input  logic [mlt_pkg::MAC_W-1:0]    mac_address,
    input  logic [mlt_pkg::PORT_W-1:0]   port_number,
    input  logic                         cfg_we,
    input  logic [mlt_pkg::TIMEOUT_W-1:0] cfg_data,
    mlt_out_if.source                    result
);
    import mlt_pkg::*;

    // Entry memories; contents are only trusted where the valid bit is set.
    logic [MAC_W-1:0]   mac_mem   [TABLE_ENTRIES];
    logic [PORT_W-1:0]  port_mem  [TABLE_ENTRIES];
    logic [STAMP_W-1:0] stamp_mem [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [STAMP_W-1:0]       seconds_reg;
    logic [TIMEOUT_W-1:0]     timeout_reg;

    logic [OP_W-1:0]   op_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [PORT_W-1:0] port_reg;

    logic [MAC_W-1:0]   rd_mac_reg;
    logic [PORT_W-1:0]  rd_port_reg;
    logic [STAMP_W-1:0] rd_stamp_reg;
    logic [INDEX_W-1:0] rd_idx_reg;
    logic               rd_vld_reg;

    logic               hit_reg;
    logic [INDEX_W-1:0] hit_idx_reg;
    logic [PORT_W-1:0]  hit_port_reg;
    logic               free_reg;
    logic [INDEX_W-1:0] free_idx_reg;
    logic [AGED_W-1:0]  aged_reg;

    logic                out_valid_reg;
    logic                found_reg;
    logic [PORT_W-1:0]   found_port_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [AGED_W-1:0]   aged_out_reg;

    logic               entry_v;
    logic               entry_match;
    logic [STAMP_W-1:0] entry_age;
    logic               entry_expired;
    logic               port_ok;
    logic               stamp_we;
    logic               entry_we;
    logic [INDEX_W-1:0] wr_idx;
    logic [STATUS_W-1:0] status_next;

    assign entry_v       = valid_reg[rd_idx_reg];
    assign entry_match   = entry_v && (rd_mac_reg == mac_reg);
    assign entry_age     = seconds_reg - rd_stamp_reg;
    assign entry_expired = entry_v && (entry_age > {{(STAMP_W-TIMEOUT_W){1'b0}}, timeout_reg});
    assign port_ok       = int'(port_reg) < PORT_COUNT;

    // Learn outcome, decided once the whole table has been scanned.
    always_comb
    begin
        stamp_we    = 1'b0;
        entry_we    = 1'b0;
        wr_idx      = hit_idx_reg;
        status_next = ST_NONE;
        if (op_reg == OP_LEARN)
        begin
            priority if (!port_ok)
            begin
                status_next = ST_DROPPED;
            end
            else if (hit_reg)
            begin
                stamp_we    = cmd.commit;
                status_next = ST_REFRESHED;
            end
            else if (free_reg)
            begin
                stamp_we    = cmd.commit;
                entry_we    = cmd.commit;
                wr_idx      = free_idx_reg;
                status_next = ST_ADDED;
            end
            else
            begin
                status_next = ST_DROPPED;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_mac_reg   <= mac_mem[cmd.rd_addr];
            rd_port_reg  <= port_mem[cmd.rd_addr];
            rd_stamp_reg <= stamp_mem[cmd.rd_addr];
            rd_idx_reg   <= cmd.rd_addr;
        end
        if (stamp_we)
        begin
            stamp_mem[wr_idx] <= seconds_reg;
        end
        if (entry_we)
        begin
            mac_mem[wr_idx]  <= mac_reg;
            port_mem[wr_idx] <= port_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            mac_reg  <= mac_address;
            port_reg <= port_number;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            seconds_reg  <= '0;
            timeout_reg  <= TIMEOUT_RESET;
            rd_vld_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            hit_port_reg <= '0;
            free_reg     <= 1'b0;
            free_idx_reg <= '0;
            aged_reg     <= '0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            if (cfg_we)
            begin
                timeout_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
                aged_reg <= '0;
                if (operation == OP_TICK)
                begin
                    seconds_reg <= seconds_reg + 1'b1;
                end
            end
            if (rd_vld_reg)
            begin
                if (entry_match && !hit_reg)
                begin
                    hit_reg      <= 1'b1;
                    hit_idx_reg  <= rd_idx_reg;
                    hit_port_reg <= rd_port_reg;
                end
                if (!entry_v && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
                // Each entry is visited once per sweep, so it can be dropped in place.
                if ((op_reg == OP_TICK) && entry_expired)
                begin
                    valid_reg[rd_idx_reg] <= 1'b0;
                    if (aged_reg != AGED_MAX)
                    begin
                        aged_reg <= aged_reg + 1'b1;
                    end
                end
            end
            if (entry_we)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            found_reg      <= (op_reg == OP_LOOKUP) && hit_reg;
            found_port_reg <= ((op_reg == OP_LOOKUP) && hit_reg) ? hit_port_reg : '0;
            status_reg     <= status_next;
            aged_out_reg   <= (op_reg == OP_TICK) ? aged_reg : '0;
        end
    end

    assign status.out_busy     = out_valid_reg && !result.ready;
    assign result.valid        = out_valid_reg;
    assign result.found        = found_reg;
    assign result.found_port   = found_port_reg;
    assign result.learn_status = status_reg;
    assign result.aged_count   = aged_out_reg;

endmodule

// ----- hdl/mlt_controller.sv -----
// Sequencer that walks the table once per operation and commits the result.
module mlt_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    output mlt_pkg::ctrl_cmd_t  cmd,
    input  mlt_pkg::dp_status_t status
);
    import mlt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SETTLE,
        S_COMMIT
    } state_t;

    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(TABLE_ENTRIES - 1);

    state_t             state_reg;
    logic [INDEX_W-1:0] idx_reg;

    assign item_ready  = (state_reg == S_IDLE);
    assign cmd.load    = item_ready && item_valid;
    assign cmd.rd_en   = (state_reg == S_SCAN);
    assign cmd.rd_addr = idx_reg;
    assign cmd.commit  = (state_reg == S_COMMIT) && !status.out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg <= S_SCAN;
                        idx_reg   <= '0;
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg == LAST_INDEX)
                    begin
                        state_reg <= S_SETTLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                // The last entry read is evaluated during this cycle.
                S_SETTLE:
                begin
                    state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    if (!status.out_busy)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- tb/mlt_result_checker.sv -----
// Checker for the MAC learning table: tracks the table contents, predicts each result and compares.
module mlt_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    mlt_in_if                             op_ch,
    mlt_out_if                            res_ch,
    input  logic                          cfg_we,
    input  logic [mlt_pkg::TIMEOUT_W-1:0] cfg_data,
    output int                            errors,
    output int                            pending
);
    import mlt_pkg::*;

    typedef struct packed {
        logic                found;
        logic [PORT_W-1:0]   found_port;
        logic [STATUS_W-1:0] learn_status;
        logic [AGED_W-1:0]   aged_count;
    } table_result_t;

    logic                 slot_valid [TABLE_ENTRIES];
    logic [MAC_W-1:0]     slot_mac   [TABLE_ENTRIES];
    logic [PORT_W-1:0]    slot_port  [TABLE_ENTRIES];
    logic [STAMP_W-1:0]   slot_stamp [TABLE_ENTRIES];
    logic [STAMP_W-1:0]   seconds_count;
    logic [TIMEOUT_W-1:0] aging_limit;
    table_result_t        expected_results [$];

    // Applies one operation to the tracked table and returns the result it must produce.
    function automatic table_result_t apply_table_op(logic [OP_W-1:0] op,
                                                     logic [MAC_W-1:0] mac,
                                                     logic [PORT_W-1:0] port);
        table_result_t      r;
        int                 hit;
        int                 free;
        int                 removed;
        logic [STAMP_W-1:0] age;
        r = '0;
        hit = -1;
        free = -1;
        removed = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (slot_valid[i] && slot_mac[i] == mac && hit < 0)
                hit = i;
            if (!slot_valid[i] && free < 0)
                free = i;
        end
        unique case (op)
            OP_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    r.found = 1'b1;
                    r.found_port = slot_port[hit];
                end
            end
            OP_LEARN:
            begin
                if (int'(port) >= PORT_COUNT)
                    r.learn_status = ST_DROPPED;
                else if (hit >= 0)
                begin
                    // A refresh keeps the stored port and only moves the time stamp.
                    slot_stamp[hit] = seconds_count;
                    r.learn_status = ST_REFRESHED;
                end
                else if (free >= 0)
                begin
                    slot_valid[free] = 1'b1;
                    slot_mac[free] = mac;
                    slot_port[free] = port;
                    slot_stamp[free] = seconds_count;
                    r.learn_status = ST_ADDED;
                end
                else
                    r.learn_status = ST_DROPPED;
            end
            OP_TICK:
            begin
                seconds_count = seconds_count + 1'b1;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    age = seconds_count - slot_stamp[i];
                    if (slot_valid[i] && age > STAMP_W'(aging_limit))
                    begin
                        slot_valid[i] = 1'b0;
                        if (removed < int'(AGED_MAX))
                            removed++;
                    end
                end
                r.aged_count = AGED_W'(removed);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t got;
        table_result_t exp;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_mac[i] = '0;
                slot_port[i] = '0;
                slot_stamp[i] = '0;
            end
            seconds_count = '0;
            aging_limit = TIMEOUT_RESET;
            expected_results.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                aging_limit = cfg_data;
            // The result leaving now always belongs to an earlier transaction, so pop first.
            if (res_ch.valid && res_ch.ready)
            begin
                got = {res_ch.found, res_ch.found_port, res_ch.learn_status, res_ch.aged_count};
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result found=%0b port=%0d status=%0d aged=%0d",
                             $time, got.found, got.found_port, got.learn_status,
                             got.aged_count);
                end
                else
                begin
                    exp = expected_results.pop_front();
                    if (got !== exp)
                    begin
                        errors++;
                        $display("%0t: mismatch expected found=%0b port=%0d status=%0d aged=%0d",
                                 $time, exp.found, exp.found_port, exp.learn_status,
                                 exp.aged_count);
                        $display("%0t:          actual   found=%0b port=%0d status=%0d aged=%0d",
                                 $time, got.found, got.found_port, got.learn_status,
                                 got.aged_count);
                    end
                end
            end
            if (op_ch.valid && op_ch.ready)
                expected_results.push_back(apply_table_op(op_ch.operation, op_ch.mac_address,
                                                          op_ch.port_number));
            pending = expected_results.size();
        end
    end

endmodule

// ----- tb/tb_mac_learning_table_with_aging.sv -----
// Top of the MAC learning table testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_mac_learning_table_with_aging;
    import mlt_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 2 * (TABLE_ENTRIES + 3);
    localparam int LONG_HOLD    = 600;
    localparam int POOL_SIZE    = 20;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [TIMEOUT_W-1:0] cfg_data;
    int                   errors;
    int                   pending;
    int                   cycle_count = 0;
    bit                   hold_req = 1'b0;
    bit                   hold_done = 1'b0;
    logic [MAC_W-1:0]     mac_pool [POOL_SIZE];

    mlt_in_if  item_ch ();
    mlt_out_if result_ch ();

    mac_learning_table_with_aging dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    mlt_result_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_ch    (item_ch),
        .res_ch   (result_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .errors   (errors),
        .pending  (pending)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MAC_W-1:0];
    endfunction

    task automatic send_op(input logic [OP_W-1:0] op, input logic [MAC_W-1:0] mac,
                           input logic [PORT_W-1:0] port);
        item_ch.valid <= 1'b1;
        item_ch.operation <= op;
        item_ch.mac_address <= mac;
        item_ch.port_number <= port;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    task automatic pause(input int n);
        item_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // The pause lets the checker record a transaction accepted at the last edge.
    task automatic wait_drained();
        pause(1);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic refill_pool();
        for (int i = 0; i < POOL_SIZE; i++)
            mac_pool[i] = random_mac();
        if ($urandom_range(0, 1) == 0)
            mac_pool[0] = '0;
        if ($urandom_range(0, 1) == 0)
            mac_pool[1] = '1;
    endtask

    task automatic pick_op(input bit fill, output logic [OP_W-1:0] op,
                           output logic [MAC_W-1:0] mac, output logic [PORT_W-1:0] port);
        int sel;
        sel = $urandom_range(0, 99);
        port = PORT_W'($urandom_range(0, 15));
        mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (fill)
        begin
            // Mostly fresh addresses so the table runs full and starts dropping.
            if (sel < 70)
            begin
                op = OP_LEARN;
                mac = random_mac();
            end
            else if (sel < 90)
                op = OP_LOOKUP;
            else
                op = OP_LEARN;
        end
        else if (sel < 35)
            op = OP_LEARN;
        else if (sel < 60)
            op = OP_LOOKUP;
        else if (sel < 78)
            op = OP_TICK;
        else if (sel < 86)
        begin
            op = OP_LOOKUP;
            mac = random_mac();
        end
        else if (sel < 92)
        begin
            op = OP_LEARN;
            mac = random_mac();
        end
        else if (sel < 97)
        begin
            op = OP_UNUSED;
            mac = random_mac();
        end
        else
        begin
            op = OP_TICK;
            mac = random_mac();
        end
    endtask

    task automatic random_stream(input int count, input bit fill, input bit steady);
        int                burst_left;
        int                gap;
        logic [OP_W-1:0]   op;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        burst_left = 0;
        for (int k = 0; k < count; k++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
                // Keep offering while the receiver holds off, so the block backs up.
                if (steady || (hold_req && !hold_done))
                    gap = 0;
                if (gap > 0)
                    pause(gap);
            end
            burst_left--;
            pick_op(fill, op, mac, port);
            send_op(op, mac, port);
        end
    endtask

    // Receiver: random stall modes, plus one long hold-off on request.
    initial
    begin
        int          mode_left;
        int          mode;
        logic [15:0] pattern;
        int          hold_count;
        mode_left = 0;
        mode = 0;
        pattern = '1;
        hold_count = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                result_ch.ready <= 1'b0;
                hold_count++;
                if (hold_count >= LONG_HOLD)
                    hold_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 300);
                    pattern = 16'($urandom);
                end
                mode_left--;
                pattern = {pattern[0], pattern[15:1]};
                unique case (mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= pattern[0];
                    2: result_ch.ready <= ($urandom_range(0, 9) < 3);
                    default: result_ch.ready <= ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    initial
    begin
        logic [TIMEOUT_W-1:0] tmo;
        int                   n;
        bit                   fill;
        item_ch.valid <= 1'b0;
        item_ch.operation <= OP_LOOKUP;
        item_ch.mac_address <= '0;
        item_ch.port_number <= '0;
        cfg_we <= 1'b0;
        cfg_data <= TIMEOUT_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset timeout: miss, adds at the address extremes,
        // hits, a refresh that must keep the stored port, the unused code and a tick.
        send_op(OP_LOOKUP, '0, '0);
        send_op(OP_LEARN, '0, '0);
        send_op(OP_LEARN, '1, 4'hF);
        send_op(OP_LOOKUP, '1, '0);
        send_op(OP_LEARN, '0, 4'd9);
        send_op(OP_LOOKUP, '0, 4'hF);
        send_op(OP_UNUSED, '1, 4'hF);
        send_op(OP_TICK, '0, '0);
        send_op(OP_LEARN, 48'h5555_5555_5555, 4'd5);
        send_op(OP_LOOKUP, 48'hAAAA_AAAA_AAAA, '0);
        send_op(OP_LOOKUP, 48'h5555_5555_5555, '0);
        send_op(OP_LEARN, 48'h5555_5555_5555, 4'd10);
        wait_drained();

        // Timeout of 1: entries go on the second tick after their last refresh.
        write_timeout(16'd1);
        send_op(OP_LEARN, 48'hAAAA_AAAA_AAAA, 4'd3);
        send_op(OP_TICK, '0, '0);
        send_op(OP_LOOKUP, 48'hAAAA_AAAA_AAAA, '0);
        send_op(OP_TICK, '0, '0);
        send_op(OP_LOOKUP, 48'hAAAA_AAAA_AAAA, '0);
        send_op(OP_LOOKUP, '0, '0);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            fill = 1'b0;
            case (ph)
                0:
                begin
                    tmo = 16'hFFFF;
                    n = 90;
                    fill = 1'b1;
                end
                1:
                begin
                    tmo = 16'd1;
                    n = 30;
                end
                2:
                begin
                    tmo = 16'd3;
                    n = 70;
                end
                3:
                begin
                    tmo = TIMEOUT_W'($urandom_range(2, 12));
                    n = 70;
                end
                4:
                begin
                    tmo = TIMEOUT_RESET;
                    n = 70;
                end
                default:
                begin
                    tmo = TIMEOUT_W'($urandom_range(1, 65535));
                    n = 40;
                end
            endcase
            wait_drained();
            write_timeout(tmo);
            refill_pool();
            if (ph == 1)
            begin
                // Two ticks right after the fill sweep the whole full table at once.
                send_op(OP_TICK, '0, '0);
                send_op(OP_TICK, '0, '0);
            end
            if (ph == 4)
                hold_req = 1'b1;
            random_stream(n, fill, ph == 2);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
